### rtl/ktfe_pkg.sv
package ktfe_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef logic [IDX_W-1:0] slot_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VAL_W-1:0] value_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   function automatic slot_type wrap_slot(input slot_type base, input count_type offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= SUM_W'(ENTRIES)) begin
         sum = sum - SUM_W'(ENTRIES);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

### rtl/ktfe_ifs.sv
interface ktfe_req_if import ktfe_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      op;
   key_type   key;
   value_type new_value;

   modport source (output valid, output op, output key, output new_value, input ready);
   modport sink   (input valid, input op, input key, input new_value, output ready);
endinterface

interface ktfe_rsp_if import ktfe_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      found;
   logic      evicted;
   key_type   evicted_key;
   value_type read_value;

   modport source (output valid, output found, output evicted, output evicted_key,
                   output read_value, input ready);
   modport sink   (input valid, input found, input evicted, input evicted_key,
                   input read_value, output ready);
endinterface

### rtl/keyed_table_fifo_evict_unit.sv
// Keyed table with first-in first-out replacement, 64 entries.
// A request is taken only in the idle state, so one transaction is in flight at a time;
// a miss scans every stored key from the oldest slot, a hit stops the scan at the match,
// and the commit waits while a prior response is still held. The scan reads the key
// memory one slot per cycle through its single read port.
// Reset (synchronous, active high) clears entry count, oldest slot and control;
// key and value memories are not cleared and no clearing pass runs.
module keyed_table_fifo_evict_unit import ktfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ktfe_req_if.sink   req_chan,
   ktfe_rsp_if.source rsp_chan
);

   key_type   key_mem   [ENTRIES];
   value_type value_mem [ENTRIES];

   state_type state_ff, state_in;
   logic      op_ff, op_in;
   key_type   key_ff, key_in;
   value_type val_ff, val_in;
   count_type pos_ff, pos_in;
   count_type count_ff, count_in;
   slot_type  oldest_ff, oldest_in;

   logic      cmp_valid_ff, cmp_valid_in;
   slot_type  cmp_slot_ff, cmp_slot_in;
   logic      cmp_last_ff, cmp_last_in;
   logic      cmp_first_ff, cmp_first_in;

   logic      hit_ff, hit_in;
   slot_type  hit_slot_ff, hit_slot_in;
   value_type hit_value_ff, hit_value_in;
   key_type   evict_key_ff, evict_key_in;

   key_type   key_rd_ff;
   value_type value_rd_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;
   logic      rsp_evicted_ff, rsp_evicted_in;
   key_type   rsp_evicted_key_ff, rsp_evicted_key_in;
   value_type rsp_read_value_ff, rsp_read_value_in;

   slot_type  rd_addr;
   slot_type  wr_addr;
   logic      key_we;
   logic      value_we;
   logic      full;
   logic      evict;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (value_we) begin
         value_mem[wr_addr] <= val_ff;
      end
      key_rd_ff   <= key_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      key_ff             <= key_in;
      val_ff             <= val_in;
      pos_ff             <= pos_in;
      cmp_slot_ff        <= cmp_slot_in;
      cmp_last_ff        <= cmp_last_in;
      cmp_first_ff       <= cmp_first_in;
      hit_ff             <= hit_in;
      hit_slot_ff        <= hit_slot_in;
      hit_value_ff       <= hit_value_in;
      evict_key_ff       <= evict_key_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
      rsp_read_value_ff  <= rsp_read_value_in;
   end

   assign full  = (count_ff == CNT_W'(ENTRIES));
   assign evict = !hit_ff && (op_ff == OP_WRITE) && full;

   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      key_in             = key_ff;
      val_in             = val_ff;
      pos_in             = pos_ff;
      count_in           = count_ff;
      oldest_in          = oldest_ff;
      cmp_valid_in       = 1'b0;
      cmp_slot_in        = cmp_slot_ff;
      cmp_last_in        = cmp_last_ff;
      cmp_first_in       = cmp_first_ff;
      hit_in             = hit_ff;
      hit_slot_in        = hit_slot_ff;
      hit_value_in       = hit_value_ff;
      evict_key_in       = evict_key_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in       = rsp_found_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      req_chan.ready     = 1'b0;
      rd_addr            = wrap_slot(oldest_ff, pos_ff);
      wr_addr            = '0;
      key_we             = 1'b0;
      value_we           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in  = req_chan.op;
               key_in = req_chan.key;
               val_in = req_chan.new_value;
               pos_in = '0;
               hit_in = 1'b0;
               state_in = (count_ff == '0) ? ST_COMMIT : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (pos_ff < count_ff) begin
               cmp_valid_in = 1'b1;
               cmp_slot_in  = rd_addr;
               cmp_last_in  = (pos_ff == count_ff - 1'b1);
               cmp_first_in = (pos_ff == '0);
               pos_in       = pos_ff + 1'b1;
            end
            if (cmp_valid_ff) begin
               if (cmp_first_ff) begin
                  evict_key_in = key_rd_ff;
               end
               if (key_rd_ff == key_ff) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = cmp_slot_ff;
                  hit_value_in = value_rd_ff;
                  cmp_valid_in = 1'b0;
                  state_in     = ST_COMMIT;
               end else if (cmp_last_ff) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = hit_ff;
               rsp_evicted_in     = evict;
               rsp_evicted_key_in = evict ? evict_key_ff : '0;
               rsp_read_value_in  = (op_ff == OP_READ && hit_ff) ? hit_value_ff : '0;
               state_in           = ST_IDLE;
               if (op_ff == OP_WRITE) begin
                  if (hit_ff) begin
                     wr_addr  = hit_slot_ff;
                     value_we = 1'b1;
                  end else if (full) begin
                     wr_addr   = oldest_ff;
                     key_we    = 1'b1;
                     value_we  = 1'b1;
                     oldest_in = wrap_slot(oldest_ff, CNT_W'(1));
                  end else begin
                     wr_addr  = wrap_slot(oldest_ff, count_ff);
                     key_we   = 1'b1;
                     value_we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_key = rsp_evicted_key_ff;
   assign rsp_chan.read_value  = rsp_read_value_ff;

endmodule

### rtl/ktfe_checker.sv
module ktfe_checker import ktfe_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      rsp_found,
   input logic      rsp_evicted,
   input key_type   rsp_evicted_key,
   input value_type rsp_read_value
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_found)
      else $error("eviction reported on a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key nonzero without eviction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_value != '0 |-> rsp_found && !rsp_evicted)
      else $error("read value without a read hit");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

endmodule

bind keyed_table_fifo_evict_unit ktfe_checker u_ktfe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found       (rsp_chan.found),
   .rsp_evicted     (rsp_chan.evicted),
   .rsp_evicted_key (rsp_chan.evicted_key),
   .rsp_read_value  (rsp_chan.read_value)
);
